@@ design/uuid_urn_text_parser_defines.svh @@
// ----------------------------------------------------------------------------
// UUID URN text parser - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef UUID_URN_TEXT_PARSER_DEFINES_SVH
`define UUID_URN_TEXT_PARSER_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define UUP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("uup assertion failed");

// Check that a condition at one edge implies another at the next edge.
`define UUP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("uup assertion failed");

`endif

@@ design/uup_pkg.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - package
// Constants, result type and character helper functions.
// ----------------------------------------------------------------------------
package uup_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 6;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned ProfW = 2;

  localparam logic [PosW-1:0] UrnLength    = 6'd45;
  localparam logic [PosW-1:0] PrefixLength = 6'd9;
  localparam logic [PosW-1:0] PositionMax  = 6'd63;
  localparam logic [PosW-1:0] HyphenPos0   = 6'd17;
  localparam logic [PosW-1:0] HyphenPos1   = 6'd22;
  localparam logic [PosW-1:0] HyphenPos2   = 6'd27;
  localparam logic [PosW-1:0] HyphenPos3   = 6'd32;
  localparam logic [CharW-1:0] CharHyphen  = 8'h2d;

  localparam logic [ProfW-1:0] ProfileGeneral = 2'd0;
  localparam logic [ProfW-1:0] ProfileLegacy  = 2'd1;
  localparam logic [ProfW-1:0] ProfileNone    = 2'd2;
  localparam logic [ProfW-1:0] ProfileReset   = ProfileGeneral;

  typedef struct packed {
    logic [CharW-1:0] uuid_byte;
    logic [IdxW-1:0]  byte_index;
    logic             byte_ready;
    logic             text_done;
    logic             accepted;
    logic             emit;
  } uup_result_t;

  function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Expected lower case character of the "urn:uuid:" prefix.
  function automatic logic [CharW-1:0] prefix_char(input logic [3:0] p);
    logic [CharW-1:0] r;
    unique case (p)
      4'd0:    r = 8'h75;  // u
      4'd1:    r = 8'h72;  // r
      4'd2:    r = 8'h6e;  // n
      4'd3:    r = 8'h3a;  // :
      4'd4:    r = 8'h75;  // u
      4'd5:    r = 8'h75;  // u
      4'd6:    r = 8'h69;  // i
      4'd7:    r = 8'h64;  // d
      4'd8:    r = 8'h3a;  // :
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Digit value in the low bits, bit 4 set when not a hex digit.
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    logic [CharW-1:0] l;
    logic [CharW-1:0] d;
    logic [4:0]       r;
    l = to_lower(c);
    r = 5'h10;
    if (l >= 8'h30 && l <= 8'h39) begin
      d = l - 8'h30;
      r = {1'b0, d[3:0]};
    end else if (l >= 8'h61 && l <= 8'h66) begin
      d = l - 8'h57;
      r = {1'b0, d[3:0]};
    end
    return r;
  endfunction

endpackage

@@ design/uup_parse_core.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - parse core
// Per-text state and the per-character check and byte decode.
// ----------------------------------------------------------------------------
module uup_parse_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [uup_pkg::CharW-1:0]    text_char_i,
  input  logic                         last_char_i,
  input  logic [uup_pkg::ProfW-1:0]    card_profile_i,
  output uup_pkg::uup_result_t         result_o
);
  import uup_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            bad_q, bad_d;
  logic [3:0]      high_q, high_d;
  logic            zero_q, zero_d;
  logic            ver_q, ver_d;
  logic            var_q, var_d;

  logic [2:0]      hyphens;
  logic [PosW-1:0] digit_full;
  logic [4:0]      digit;
  logic [4:0]      hex;
  logic [3:0]      nib;
  logic            is_hyphen;
  logic            ok;

  always_comb begin
    pos_d  = pos_q;
    bad_d  = bad_q;
    high_d = high_q;
    zero_d = zero_q;
    ver_d  = ver_q;
    var_d  = var_q;
    result_o = '0;

    is_hyphen = (pos_q == HyphenPos0) || (pos_q == HyphenPos1) ||
                (pos_q == HyphenPos2) || (pos_q == HyphenPos3);
    hyphens = {2'b00, pos_q > HyphenPos0} + {2'b00, pos_q > HyphenPos1} +
              {2'b00, pos_q > HyphenPos2} + {2'b00, pos_q > HyphenPos3};
    digit_full = pos_q - PrefixLength - {3'b000, hyphens};
    digit = digit_full[4:0];
    hex   = hex_value(text_char_i);
    nib   = hex[4] ? 4'h0 : hex[3:0];

    if (pos_q >= UrnLength) begin
      bad_d = 1'b1;
    end else if (pos_q < PrefixLength) begin
      if (to_lower(text_char_i) != prefix_char(pos_q[3:0])) begin
        bad_d = 1'b1;
      end
    end else if (is_hyphen) begin
      if (text_char_i != CharHyphen) begin
        bad_d = 1'b1;
      end
    end else begin
      if (hex[4]) begin
        bad_d = 1'b1;
      end
      if (nib != 4'h0) begin
        zero_d = 1'b0;
      end
      if (!digit[0]) begin
        high_d = nib;
        if (digit[4:1] == 4'd6) begin
          ver_d = (nib == 4'd1) || (nib == 4'd4) || (nib == 4'd5);
        end
        if (digit[4:1] == 4'd8) begin
          var_d = (nib[3:2] == 2'b10);
        end
      end else if (!bad_d) begin
        result_o.byte_ready = 1'b1;
        result_o.uuid_byte  = {high_q, nib};
        result_o.byte_index = digit[4:1];
      end
    end

    if (pos_q != PositionMax) begin
      pos_d = pos_q + 6'd1;
    end

    ok = !bad_d && (pos_q == UrnLength - 6'd1);
    unique case (card_profile_i)
      ProfileGeneral: ok = ok && ver_d && var_d;
      ProfileLegacy:  ok = ok && zero_d;
      ProfileNone:    ok = ok;
      default:        ok = 1'b0;
    endcase

    result_o.text_done = last_char_i;
    result_o.accepted  = last_char_i && ok;
    result_o.emit      = result_o.byte_ready || last_char_i;

    // Start over for the next text.
    if (last_char_i) begin
      pos_d  = '0;
      bad_d  = 1'b0;
      high_d = 4'h0;
      zero_d = 1'b1;
      ver_d  = 1'b0;
      var_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      bad_q  <= 1'b0;
      high_q <= 4'h0;
      zero_q <= 1'b1;
      ver_q  <= 1'b0;
      var_q  <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      bad_q  <= bad_d;
      high_q <= high_d;
      zero_q <= zero_d;
      ver_q  <= ver_d;
      var_q  <= var_d;
    end
  end

endmodule

@@ design/uuid_urn_text_parser.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - top level
// Checks a "urn:uuid:" text one character per word and streams out the
// decoded UUID bytes, then reports whether the whole text was accepted.
// ----------------------------------------------------------------------------
//   channel   dir  tdata                         tuser                  tlast
//   s_axis    in   text_char[7:0]                -                      last_char
//   m_axis    out  uuid_byte[7:0],byte_index     byte_ready,accepted    text_done
//   cfg       in   card_profile[1:0] on card_profile_we_i, no read-back
//
// One character word per cycle sustained while m_axis is not stalled; each word
// passes the input register, the check stage and then the output register.
// A word that neither completes a byte nor ends the text gives no output.
// Reset clears the handshake valids, the profile register and text state.
// A stall on m_axis holds the output register and then the input register;
// s_axis_tready_o drops only when both are full and the output is stalled.
// ----------------------------------------------------------------------------
module uuid_urn_text_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [uup_pkg::CharW-1:0]  s_axis_tdata_i,   // [7:0] text_char
  input  logic                       s_axis_tlast_i,   // last_char
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [15:0]                m_axis_tdata_o,   // [7:0] uuid_byte,
                                                       // [11:8] byte_index, [15:12] 0
  output logic [1:0]                 m_axis_tuser_o,   // [0] byte_ready, [1] accepted
  output logic                       m_axis_tlast_o,   // text_done
  input  logic                       card_profile_we_i,
  input  logic [uup_pkg::ProfW-1:0]  card_profile_i
);
  import uup_pkg::*;

  // Input register
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  uup_result_t      out_res_q;

  logic [ProfW-1:0] profile_q;
  uup_result_t      core_res;
  logic             advance;
  logic             step;

  // Output register frees up when empty or being taken this cycle.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      // Drop words that cause no result.
      out_valid_d = step && core_res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      profile_q   <= ProfileReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (card_profile_we_i) begin
        profile_q <= card_profile_i;
      end
    end
  end

  // Payload registers: load only, no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (step) begin
      out_res_q <= core_res;
    end
  end

  uup_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .text_char_i    (in_char_q),
    .last_char_i    (in_last_q),
    .card_profile_i (profile_q),
    .result_o       (core_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_res_q.byte_index, out_res_q.uuid_byte};
  assign m_axis_tuser_o  = {out_res_q.accepted, out_res_q.byte_ready};
  assign m_axis_tlast_o  = out_res_q.text_done;

endmodule

@@ design/uup_checker.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - port checker
// Assertions on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "uuid_urn_text_parser_defines.svh"

module uup_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled word stays offered.
  `UUP_ASSERT_NEXT(a_hold_valid, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // Every word carries a byte, an end of text, or both.
  `UUP_ASSERT_ALWAYS(a_no_empty, !m_axis_tvalid_o || m_axis_tuser_o[0] || m_axis_tlast_o)

  // Acceptance only shows on the end of text.
  `UUP_ASSERT_ALWAYS(a_acc_last, !m_axis_tvalid_o || !m_axis_tuser_o[1] || m_axis_tlast_o)

  // Without a byte the byte fields read zero.
  `UUP_ASSERT_ALWAYS(a_zero_data, !m_axis_tvalid_o || m_axis_tuser_o[0] || m_axis_tdata_o == 16'h0)

endmodule

bind uuid_urn_text_parser uup_checker u_checker (.*);

@@ verif/uuid_urn_text_parser_checker.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - stream checker
// Watches the character and result channels and the profile register.
// Predicts each result word from the accepted characters and compares it,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module uuid_urn_text_parser_checker
  import uup_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  logic             s_axis_tready_i,
  input  logic [CharW-1:0] s_axis_tdata_i,    // [7:0] text_char
  input  logic             s_axis_tlast_i,    // last_char
  input  logic             m_axis_tvalid_i,
  input  logic             m_axis_tready_i,
  input  logic [15:0]      m_axis_tdata_i,    // [7:0] uuid_byte, [11:8] byte_index
  input  logic [1:0]       m_axis_tuser_i,    // [0] byte_ready, [1] accepted
  input  logic             m_axis_tlast_i,    // text_done
  input  logic             card_profile_we_i,
  input  logic [ProfW-1:0] card_profile_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*9-1:0] UrnPrefix = "urn:uuid:";

  typedef struct packed {
    logic [7:0] uuid_byte;
    logic [3:0] byte_index;
    logic       byte_ready;
    logic       text_done;
    logic       accepted;
  } urn_word_t;

  urn_word_t       words_due [$];
  urn_word_t       got_word;
  urn_word_t       want_word;
  int              reports;

  logic [PosW-1:0]  char_pos;
  logic             text_bad;
  logic [3:0]       pend_nibble;
  logic             zeros_only;
  logic             version_ok;
  logic             variant_ok;
  logic [ProfW-1:0] profile_sel;

  function automatic logic is_hyphen_slot(input logic [PosW-1:0] p);
    return p == HyphenPos0 || p == HyphenPos1 || p == HyphenPos2 || p == HyphenPos3;
  endfunction

  // Fold one character into the parse state; queue the word it causes, if any.
  task automatic absorb_char(input logic [CharW-1:0] c, input logic last);
    logic [PosW-1:0]  p;
    logic [CharW-1:0] lc;
    logic [3:0]       nib;
    int               hy;
    int               dig;
    logic             ok;
    urn_word_t        w;
    p  = char_pos;
    w  = '0;
    lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    if (p >= UrnLength) begin
      text_bad = 1'b1;
    end else if (p < PrefixLength) begin
      if (lc != UrnPrefix[8*(8-int'(p)) +: 8]) text_bad = 1'b1;
    end else if (is_hyphen_slot(p)) begin
      if (c != CharHyphen) text_bad = 1'b1;
    end else begin
      hy  = int'(p > HyphenPos0) + int'(p > HyphenPos1) + int'(p > HyphenPos2) +
            int'(p > HyphenPos3);
      dig = int'(p) - int'(PrefixLength) - hy;
      if (lc >= 8'h30 && lc <= 8'h39) begin
        nib = 4'(lc - 8'h30);
      end else if (lc >= 8'h61 && lc <= 8'h66) begin
        nib = 4'(lc - 8'h57);
      end else begin
        text_bad = 1'b1;
        nib      = 4'd0;
      end
      if (nib != 4'd0) zeros_only = 1'b0;
      if (dig % 2 == 0) begin
        pend_nibble = nib;
        if (dig / 2 == 6) version_ok = (nib == 4'd1 || nib == 4'd4 || nib == 4'd5);
        if (dig / 2 == 8) variant_ok = ((nib & 4'hc) == 4'h8);
      end else if (!text_bad) begin
        w.byte_ready = 1'b1;
        w.uuid_byte  = {pend_nibble, nib};
        w.byte_index = 4'(dig / 2);
      end
    end
    if (char_pos < PositionMax) char_pos = char_pos + 1'b1;
    if (w.byte_ready || last) begin
      w.text_done = last;
      if (last) begin
        ok = !text_bad && p == UrnLength - 1'b1;
        case (profile_sel)
          ProfileGeneral: ok = ok && version_ok && variant_ok;
          ProfileLegacy:  ok = ok && zeros_only;
          ProfileNone:    ok = ok;
          default:        ok = 1'b0;
        endcase
        w.accepted = ok;
      end
      words_due.push_back(w);
    end
    if (last) begin
      char_pos    = '0;
      text_bad    = 1'b0;
      pend_nibble = '0;
      zeros_only  = 1'b1;
      version_ok  = 1'b0;
      variant_ok  = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      words_due.delete();
      reports      = 0;
      fail_count_o = 0;
      char_pos     = '0;
      text_bad     = 1'b0;
      pend_nibble  = '0;
      zeros_only   = 1'b1;
      version_ok   = 1'b0;
      variant_ok   = 1'b0;
      profile_sel  = ProfileReset;
    end else begin
      // Retire the output side first: no word can leave in the cycle its
      // character enters.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_word.uuid_byte  = m_axis_tdata_i[7:0];
        got_word.byte_index = m_axis_tdata_i[11:8];
        got_word.byte_ready = m_axis_tuser_i[0];
        got_word.accepted   = m_axis_tuser_i[1];
        got_word.text_done  = m_axis_tlast_i;
        if (words_due.size() == 0) begin
          fail_count_o++;
          if (reports < 10) begin
            reports++;
            $display("unexpected word: byte %02h idx %0d rdy %b done %b acc %b",
                     got_word.uuid_byte, got_word.byte_index, got_word.byte_ready,
                     got_word.text_done, got_word.accepted);
          end
        end else begin
          want_word = words_due.pop_front();
          if (got_word !== want_word || m_axis_tdata_i[15:12] !== 4'h0) begin
            fail_count_o++;
            if (reports < 10) begin
              reports++;
              $display("mismatch: exp byte %02h idx %0d rdy %b done %b acc %b",
                       want_word.uuid_byte, want_word.byte_index, want_word.byte_ready,
                       want_word.text_done, want_word.accepted);
              $display("          got byte %02h idx %0d rdy %b done %b acc %b pad %h",
                       got_word.uuid_byte, got_word.byte_index, got_word.byte_ready,
                       got_word.text_done, got_word.accepted, m_axis_tdata_i[15:12]);
            end
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        absorb_char(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (card_profile_we_i) profile_sel = card_profile_i;
    end
    pending_o = words_due.size();
  end

endmodule

@@ verif/uuid_urn_text_parser_tb.sv @@
// ----------------------------------------------------------------------------
// UUID URN text parser - testbench top
// Streams URN texts into the parser: a few short hand-picked texts, then
// mostly well-formed texts with random content, corrupted, cut short or
// overlong texts, and noise, under every profile setting. The checker
// beside the block predicts and compares; this module only drives and
// gives the verdict.
// ----------------------------------------------------------------------------
module uuid_urn_text_parser_tb
  import uup_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget   = 1050;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned DrainCycles  = 6;    // lets the input and output registers empty
  localparam int unsigned PressureAt   = 150;  // result word that starts the hold
  localparam int unsigned PressureHold = 400;
  localparam logic [ProfW-1:0] ProfileUnused = 2'd3;
  localparam logic [8*9-1:0]   UrnPrefix     = "urn:uuid:";

  typedef enum int {
    TextGood, TextRandomHex, TextZero, TextCorrupt, TextShort, TextLong, TextNoise
  } text_kind_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_tvalid = 1'b0;
  logic [CharW-1:0] s_tdata = '0;
  logic             s_tlast = 1'b0;
  logic             m_tready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [ProfW-1:0] cfg_data = '0;

  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [15:0]      m_axis_tdata_o;
  logic [1:0]       m_axis_tuser_o;
  logic             m_axis_tlast_o;

  int               fail_count;
  int               pending;
  int               items_sent = 0;
  int unsigned      cycle_count = 0;
  bit               tx_eager = 1'b0;   // sender offers back to back
  bit               rx_eager = 1'b0;   // receiver does not stall between words, but for the one long hold
  logic [7:0]       text_buf [$];

  uuid_urn_text_parser DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid_i   (s_tvalid),
    .s_axis_tready_o   (s_axis_tready_o),
    .s_axis_tdata_i    (s_tdata),
    .s_axis_tlast_i    (s_tlast),
    .m_axis_tvalid_o   (m_axis_tvalid_o),
    .m_axis_tready_i   (m_tready),
    .m_axis_tdata_o    (m_axis_tdata_o),
    .m_axis_tuser_o    (m_axis_tuser_o),
    .m_axis_tlast_o    (m_axis_tlast_o),
    .card_profile_we_i (cfg_we),
    .card_profile_i    (cfg_data)
  );

  uuid_urn_text_parser_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid_i   (s_tvalid),
    .s_axis_tready_i   (s_axis_tready_o),
    .s_axis_tdata_i    (s_tdata),
    .s_axis_tlast_i    (s_tlast),
    .m_axis_tvalid_i   (m_axis_tvalid_o),
    .m_axis_tready_i   (m_tready),
    .m_axis_tdata_i    (m_axis_tdata_o),
    .m_axis_tuser_i    (m_axis_tuser_o),
    .m_axis_tlast_i    (m_axis_tlast_o),
    .card_profile_we_i (cfg_we),
    .card_profile_i    (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: end the run as failed once CycleLimit is reached.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("uuid_urn_text_parser_tb NOT OK");
      $finish;
    end
  end

  // Hex digit of a nibble, letters in random case.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    c = (n < 4'd10) ? 8'h30 + n : 8'h57 + n;
    if (c >= 8'h61 && $urandom_range(0, 1) == 1) c = c - 8'd32;
    return c;
  endfunction

  // Fill the text buffer from a string literal.
  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Build one text of the given kind into the buffer.
  task automatic build_urn(input text_kind_e kind);
    logic [3:0] nib [32];
    logic [7:0] c;
    int         cut;
    text_buf.delete();
    if (kind == TextNoise) begin
      repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom));
      return;
    end
    // Prefix with each letter in random case.
    for (int i = 0; i < 9; i++) begin
      c = UrnPrefix[8*(8-i) +: 8];
      if (c >= 8'h61 && $urandom_range(0, 1) == 1) c = c - 8'd32;
      text_buf.push_back(c);
    end
    for (int i = 0; i < 32; i++) nib[i] = (kind == TextZero) ? 4'd0 : 4'($urandom);
    if (kind == TextGood) begin
      // Version nibble leads byte 6, variant bits lead byte 8.
      case ($urandom_range(0, 2))
        0:       nib[12] = 4'd1;
        1:       nib[12] = 4'd4;
        default: nib[12] = 4'd5;
      endcase
      nib[16] = 4'($urandom_range(8, 11));
    end
    for (int i = 0; i < 32; i++) begin
      if (i == 8 || i == 12 || i == 16 || i == 20) text_buf.push_back(CharHyphen);
      text_buf.push_back(hex_char(nib[i]));
    end
    case (kind)
      TextCorrupt: text_buf[$urandom_range(0, 44)] = 8'($urandom);
      TextShort: begin
        cut = $urandom_range(1, 44);
        while (text_buf.size() > cut) void'(text_buf.pop_back());
      end
      TextLong: repeat ($urandom_range(1, 25)) text_buf.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // Offer one character word and hold it until accepted.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // Stream the buffer out, flagging the last character.
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  // Drop valid, wait for every predicted word, then let the pipe empty of
  // characters that cause no word.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_profile(input logic [ProfW-1:0] prof);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= prof;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Receiver: after each word, stall at random unless eager; once, hold off for a long
  // stretch so the block fills and backs up its input.
  initial begin : rx_side
    int stall_left;
    int words_taken;
    bit pressed;
    stall_left  = 0;
    words_taken = 0;
    pressed     = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_tready) begin
        words_taken++;
        stall_left = rx_eager ? 0 : $urandom_range(0, 3);
        if (!pressed && words_taken == PressureAt) begin
          stall_left = PressureHold;
          pressed    = 1'b1;
        end
      end
      m_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : tx_side
    int               phase;
    int               pick;
    text_kind_e       kind;
    logic [ProfW-1:0] prof;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-picked texts under the reset profile: extreme characters as a
    // one-character text, a cut-off mixed-case prefix, a byte completed on
    // the last character, and a bad digit that suppresses its byte.
    text_buf.delete();
    text_buf.push_back(8'h00);
    send_text();
    text_buf.delete();
    text_buf.push_back(8'hff);
    send_text();
    load_text("UrN");
    send_text();
    load_text("uRn:UuId:aF");
    send_text();
    load_text("urn:uuid:g0");
    send_text();

    // Random phases: sweep every profile value first, then pick at random.
    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0:       prof = ProfileNone;
        1:       prof = ProfileLegacy;
        2:       prof = ProfileUnused;
        3:       prof = ProfileGeneral;
        default: prof = ProfW'($urandom_range(0, 3));
      endcase
      write_profile(prof);
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      for (int t = 0; t < 5 && items_sent < ItemTarget; t++) begin
        pick = $urandom_range(0, 99);
        if      (pick < 25) kind = TextGood;
        else if (pick < 40) kind = TextRandomHex;
        else if (pick < 55) kind = TextZero;
        else if (pick < 70) kind = TextCorrupt;
        else if (pick < 80) kind = TextShort;
        else if (pick < 90) kind = TextLong;
        else                kind = TextNoise;
        build_urn(kind);
        send_text();
      end
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("uuid_urn_text_parser_tb OK");
    end else begin
      $display("uuid_urn_text_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
